// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, held off during reset
`define SSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// condition that must never hold outside reset
`define SSE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// File: design/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

  localparam int unsigned DEF_NUM_TERMS  = 3;
  localparam int unsigned DEF_SINE_DEPTH = 1024;

  localparam int COEF_W    = 32;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 66;
  localparam int SINE_W    = 17;
  localparam int MODEL_W   = 56;
  localparam int ACC_W     = 64;
  localparam int SQ_W      = 66;
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 64;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  // floor(2^32 / 360)
  localparam logic [23:0] RECIP_360   = 24'd11930464;
  localparam int unsigned DEG_TURN    = 360;
  localparam int unsigned HALF_TURN   = 180;
  // 2^31 mod 360
  localparam int unsigned BIAS_MOD    = 128;

  typedef enum logic {
    CMD_COEF  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_e;

  typedef struct packed {
    logic signed [MUL_W-1:0] opa;
    logic signed [MUL_W-1:0] opb;
  } mul_op_t;

endpackage

// File: design/sse_mul.sv
`timescale 1ns / 1ps

module sse_mul (
  input  logic                                 clk_i,
  input  sse_pkg::mul_op_t                     op_i,
  output logic signed [sse_pkg::PROD_W-1:0]    prod_o
);

  logic signed [sse_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= op_i.opa * op_i.opb;
  end

  assign prod_o = prod_q;

endmodule

// File: design/sse_sine_rom.sv
`timescale 1ns / 1ps

module sse_sine_rom #(
  parameter int unsigned DEPTH = sse_pkg::DEF_SINE_DEPTH
) (
  input  logic                           clk_i,
  input  logic [$clog2(DEPTH+1)-1:0]     addr_i,
  output logic [sse_pkg::SINE_W-1:0]     data_o
);

  logic [sse_pkg::SINE_W-1:0] rom_w [DEPTH+1];
  logic [sse_pkg::SINE_W-1:0] data_q;

  // quarter wave, taylor series in q2.30 rounded to unsigned q1.16
  for (genvar i = 0; i <= DEPTH; i++) begin : g_rom
    localparam logic [63:0] THETA = (64'(i) * sse_pkg::HALF_PI_Q30) / 64'(DEPTH);
    localparam logic [63:0] X2 = (THETA * THETA) >> 30;
    localparam logic [63:0] T1 = ((THETA * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] SUM = THETA - T1 + T2 - T3 + T4 - T5 + T6;
    localparam logic [63:0] QV = (SUM + 64'd8192) >> 14;
    localparam logic [63:0] VAL = (QV > 64'd65536) ? 64'd65536 : QV;
    assign rom_w[i] = VAL[sse_pkg::SINE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

// File: design/sine_sum_squared_error.sv
// a result enters the output register when the point flagged last is accumulated
// points are taken one at a time: a new point is accepted only in idle, after the
// sequencer has walked every step of the last one through the single registered multiplier
// a coefficient write is taken in idle, and writes may follow each other every cycle while idle
// reset clears the coefficients, the accumulator and the saturation flag; no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sine_sum_squared_error #(
  parameter int unsigned NUM_TERMS        = sse_pkg::DEF_NUM_TERMS,
  parameter int unsigned SINE_TABLE_DEPTH = sse_pkg::DEF_SINE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // coef_index[3:0], coef_value[35:4], point_x[67:36], point_y[99:68], zero fill
  input  logic [sse_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // command
  input  logic                            s_axis_tuser_i,
  // last_point
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // squared_error_sum[63:0]
  output logic [sse_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // saturated
  output logic                            m_axis_tuser_o
);

  localparam int COEF_COUNT = 3 * NUM_TERMS + 1;
  localparam int CAW        = $clog2(COEF_COUNT);
  localparam int TERM_W     = $clog2(NUM_TERMS + 1);
  localparam int FOUR_D     = 4 * SINE_TABLE_DEPTH;
  localparam int IDX_W      = $clog2(FOUR_D + 1);
  localparam int T_W        = $clog2(360 * FOUR_D + 181);
  localparam int ROM_AW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MW         = sse_pkg::MODEL_W;
  localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(NUM_TERMS - 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_KX    = 5'd1;
  localparam logic [4:0] ST_ANG   = 5'd2;
  localparam logic [4:0] ST_UR    = 5'd3;
  localparam logic [4:0] ST_F4D   = 5'd4;
  localparam logic [4:0] ST_TR    = 5'd5;
  localparam logic [4:0] ST_TQ    = 5'd6;
  localparam logic [4:0] ST_IDX   = 5'd7;
  localparam logic [4:0] ST_QD    = 5'd8;
  localparam logic [4:0] ST_ROM   = 5'd9;
  localparam logic [4:0] ST_AS    = 5'd10;
  localparam logic [4:0] ST_ADD   = 5'd11;
  localparam logic [4:0] ST_ERR   = 5'd12;
  localparam logic [4:0] ST_SQLL  = 5'd13;
  localparam logic [4:0] ST_SQHL  = 5'd14;
  localparam logic [4:0] ST_SQHH  = 5'd15;
  localparam logic [4:0] ST_SQFIN = 5'd16;
  localparam logic [4:0] ST_ACC   = 5'd17;

  logic [4:0] state_q, state_d;
  logic [TERM_W-1:0] term_q;

  logic signed [sse_pkg::COEF_W-1:0] coef_q [COEF_COUNT];
  logic signed [sse_pkg::COEF_W-1:0] x_q, y_q;
  logic last_q;

  logic signed [MW-1:0] model_q;
  logic [63:0] ang_q;
  logic [8:0] rem_q;
  logic [T_W-1:0] t_q;
  logic [IDX_W-1:0] idx_q;
  logic [ROM_AW-1:0] addr_q;
  logic neg_q;
  logic [MW-1:0] mag_q;
  logic [sse_pkg::SQ_W-1:0] sq_q;
  logic [sse_pkg::ACC_W-1:0] acc_q;
  logic ovf_q;
  logic m_valid_q;
  logic [sse_pkg::M_TDATA_W-1:0] m_data_q;
  logic m_user_q;

  logic in_xfer, acc_go;
  logic [3:0] in_index;
  logic signed [sse_pkg::COEF_W-1:0] in_value, in_x, in_y;
  logic [CAW-1:0] rd_addr;
  logic signed [sse_pkg::COEF_W-1:0] coef_rd, coef_c;

  sse_pkg::mul_op_t mul_op;
  logic signed [sse_pkg::PROD_W-1:0] prod;
  logic [sse_pkg::SINE_W-1:0] rom_data;

  logic [31:0] ang_u, ang_f;
  logic [23:0] q0;
  logic [32:0] v33;
  logic [9:0] v;
  logic [8:0] rem_d;
  logic [IDX_W-1:0] fx, q0t, idx_c, idx_d, j;
  logic [T_W-1:0] t_d;
  logic [T_W:0] dr;
  logic [1:0] quad;
  logic signed [sse_pkg::SINE_W:0] sine_s;
  logic signed [MW-1:0] err;
  logic sat_sq, sat_all;
  logic [sse_pkg::ACC_W-1:0] sq_clamp, acc_new;
  logic [sse_pkg::ACC_W:0] sum_w;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_index = s_axis_tdata_i[3:0];
  assign in_value = s_axis_tdata_i[35:4];
  assign in_x     = s_axis_tdata_i[67:36];
  assign in_y     = s_axis_tdata_i[99:68];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign acc_go          = !m_valid_q || m_axis_tready_i;

  always_comb begin
    case (state_q)
      ST_KX:   rd_addr = CAW'(3) * CAW'(term_q) + CAW'(1);
      ST_ANG:  rd_addr = CAW'(3) * CAW'(term_q) + CAW'(2);
      default: rd_addr = CAW'(3) * CAW'(term_q);
    endcase
  end

  assign coef_rd = coef_q[rd_addr];
  assign coef_c  = coef_q[COEF_COUNT-1];

  // angle reduction
  assign ang_u = ang_q[63:32] ^ 32'h8000_0000;
  assign ang_f = ang_q[31:0];
  assign q0    = prod[55:32];
  assign v33   = {1'b0, ang_u} - 33'(q0) * 33'(sse_pkg::DEG_TURN);
  assign v     = v33[9:0];

  always_comb begin
    if (v < 10'(sse_pkg::BIAS_MOD)) begin
      rem_d = 9'(v + 10'(sse_pkg::DEG_TURN - sse_pkg::BIAS_MOD));
    end else if (v >= 10'(sse_pkg::DEG_TURN + sse_pkg::BIAS_MOD)) begin
      rem_d = 9'(v - 10'(sse_pkg::DEG_TURN + sse_pkg::BIAS_MOD));
    end else begin
      rem_d = 9'(v - 10'(sse_pkg::BIAS_MOD));
    end
  end

  assign fx  = prod[32 +: IDX_W];
  assign t_d = T_W'(rem_q) * T_W'(FOUR_D) + T_W'(fx) + T_W'(sse_pkg::HALF_TURN);

  // table step from the reciprocal estimate with one correction
  assign q0t   = prod[32 +: IDX_W];
  assign dr    = (T_W+1)'(t_q) - (T_W+1)'(q0t) * (T_W+1)'(sse_pkg::DEG_TURN);
  assign idx_c = (dr >= (T_W+1)'(sse_pkg::DEG_TURN)) ? q0t + IDX_W'(1) : q0t;
  assign idx_d = (idx_c == IDX_W'(FOUR_D)) ? '0 : idx_c;

  always_comb begin
    if (idx_q >= IDX_W'(3 * SINE_TABLE_DEPTH)) begin
      quad = 2'd3;
      j    = idx_q - IDX_W'(3 * SINE_TABLE_DEPTH);
    end else if (idx_q >= IDX_W'(2 * SINE_TABLE_DEPTH)) begin
      quad = 2'd2;
      j    = idx_q - IDX_W'(2 * SINE_TABLE_DEPTH);
    end else if (idx_q >= IDX_W'(SINE_TABLE_DEPTH)) begin
      quad = 2'd1;
      j    = idx_q - IDX_W'(SINE_TABLE_DEPTH);
    end else begin
      quad = 2'd0;
      j    = idx_q;
    end
  end

  assign sine_s = neg_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

  assign err = $signed({{(MW-48){y_q[31]}}, y_q, 16'h0000}) - model_q;

  assign sat_sq   = (|mag_q[MW-1:48]) || (|sq_q[sse_pkg::SQ_W-1:64]);
  assign sq_clamp = sat_sq ? '1 : sq_q[63:0];
  assign sum_w    = {1'b0, acc_q} + {1'b0, sq_clamp};
  assign sat_all  = sat_sq || sum_w[sse_pkg::ACC_W];
  assign acc_new  = sat_all ? '1 : sum_w[sse_pkg::ACC_W-1:0];

  always_comb begin
    mul_op = '0;
    case (state_q)
      ST_KX: begin
        mul_op.opa = sse_pkg::MUL_W'(coef_rd);
        mul_op.opb = sse_pkg::MUL_W'(x_q);
      end
      ST_UR: begin
        mul_op.opa = $signed({1'b0, ang_u});
        mul_op.opb = $signed(sse_pkg::MUL_W'(sse_pkg::RECIP_360));
      end
      ST_F4D: begin
        mul_op.opa = $signed({1'b0, ang_f});
        mul_op.opb = sse_pkg::MUL_W'(FOUR_D);
      end
      ST_TQ: begin
        mul_op.opa = $signed(sse_pkg::MUL_W'(t_q));
        mul_op.opb = $signed(sse_pkg::MUL_W'(sse_pkg::RECIP_360));
      end
      ST_AS: begin
        mul_op.opa = sse_pkg::MUL_W'(coef_rd);
        mul_op.opb = sse_pkg::MUL_W'(sine_s);
      end
      ST_SQLL: begin
        mul_op.opa = $signed({1'b0, mag_q[31:0]});
        mul_op.opb = $signed({1'b0, mag_q[31:0]});
      end
      ST_SQHL: begin
        mul_op.opa = $signed(sse_pkg::MUL_W'(mag_q[47:32]));
        mul_op.opb = $signed({1'b0, mag_q[31:0]});
      end
      ST_SQHH: begin
        mul_op.opa = $signed(sse_pkg::MUL_W'(mag_q[47:32]));
        mul_op.opb = $signed(sse_pkg::MUL_W'(mag_q[47:32]));
      end
      default: begin
        mul_op = '0;
      end
    endcase
  end

  sse_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  sse_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (addr_q),
    .data_o (rom_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (s_axis_tuser_i == sse_pkg::CMD_POINT)) begin
          state_d = ST_KX;
        end
      end
      ST_KX:    state_d = ST_ANG;
      ST_ANG:   state_d = ST_UR;
      ST_UR:    state_d = ST_F4D;
      ST_F4D:   state_d = ST_TR;
      ST_TR:    state_d = ST_TQ;
      ST_TQ:    state_d = ST_IDX;
      ST_IDX:   state_d = ST_QD;
      ST_QD:    state_d = ST_ROM;
      ST_ROM:   state_d = ST_AS;
      ST_AS:    state_d = ST_ADD;
      ST_ADD:   state_d = (term_q == TERM_LAST) ? ST_ERR : ST_KX;
      ST_ERR:   state_d = ST_SQLL;
      ST_SQLL:  state_d = ST_SQHL;
      ST_SQHL:  state_d = ST_SQHH;
      ST_SQHH:  state_d = ST_SQFIN;
      ST_SQFIN: state_d = ST_ACC;
      ST_ACC: begin
        if (acc_go) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      term_q    <= '0;
      acc_q     <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < COEF_COUNT; i++) begin
        coef_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if ((state_q == ST_ACC) && acc_go && last_q) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          term_q <= '0;
          if (in_xfer && (s_axis_tuser_i == sse_pkg::CMD_COEF) &&
              ({1'b0, in_index} < 5'(COEF_COUNT))) begin
            coef_q[CAW'(in_index)] <= in_value;
          end
        end
        ST_ADD: begin
          if (term_q != TERM_LAST) begin
            term_q <= term_q + TERM_W'(1);
          end
        end
        ST_ACC: begin
          if (acc_go) begin
            if (last_q) begin
              acc_q     <= '0;
              ovf_q     <= 1'b0;
            end else begin
              acc_q <= acc_new;
              ovf_q <= ovf_q || sat_all;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          x_q     <= in_x;
          y_q     <= in_y;
          last_q  <= s_axis_tlast_i;
          model_q <= $signed({{(MW-48){coef_c[31]}}, coef_c, 16'h0000});
        end
      end
      ST_ANG: begin
        ang_q <= prod[63:0] + {{16{coef_rd[31]}}, coef_rd, 16'h0000};
      end
      ST_F4D: rem_q <= rem_d;
      ST_TR:  t_q   <= t_d;
      ST_IDX: idx_q <= idx_d;
      ST_QD: begin
        addr_q <= quad[0] ? ROM_AW'(IDX_W'(SINE_TABLE_DEPTH) - j) : ROM_AW'(j);
        neg_q  <= quad[1];
      end
      ST_ADD: model_q <= model_q + $signed(prod[MW-1:0]);
      ST_ERR: mag_q   <= err[MW-1] ? MW'(-err) : MW'(err);
      ST_SQHL: sq_q   <= sse_pkg::SQ_W'(prod[63:32]);
      ST_SQHH: sq_q   <= sq_q + (sse_pkg::SQ_W'(prod[47:0]) << 1);
      ST_SQFIN: sq_q  <= sq_q + (sse_pkg::SQ_W'(prod[31:0]) << 32);
      ST_ACC: begin
        if (acc_go && last_q) begin
          m_data_q <= acc_new;
          m_user_q <= ovf_q || sat_all;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  `SSE_ASSERT(a_result_from_acc, $rose(m_axis_tvalid_o) |-> $past(state_q == ST_ACC))
  `SSE_ASSERT(a_clear_after_result, (state_q == ST_ACC && acc_go && last_q) |=> (acc_q == '0 && !ovf_q))
  `SSE_ASSERT_NEVER(a_term_in_range, term_q > TERM_LAST)

endmodule
